### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### hdl/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// Constants, types and helper functions of the bounded 48-bit LCG generator.
// ----------------------------------------------------------------------------
package lbr_pkg;

  localparam int STATE_W   = 48;
  localparam int DRAW_W    = 31;
  localparam int MUL_STEPS = 35;  // significant bits of the multiplier
  localparam int DIV_STEPS = DRAW_W;

  localparam logic [STATE_W-1:0] LCG_MULT   = 48'h0005_DEEC_E66D;
  localparam logic [STATE_W-1:0] LCG_ADD    = 48'h0000_0000_000B;
  localparam logic [STATE_W-1:0] SEED_RESET = 48'h0000_5442_4C4F;

  // item kinds carried on tuser
  localparam logic ACT_DRAW    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } lbr_state_t;

  // zero counts as a power of two
  function automatic logic is_pow2(input logic [DRAW_W-1:0] b);
    return (b & (b - DRAW_W'(1))) == '0;
  endfunction

  // (bound * bits) >> 31 for a one-hot (or zero) bound
  function automatic logic [DRAW_W-1:0] pow2_scale(input logic [DRAW_W-1:0] bits,
                                                    input logic [DRAW_W-1:0] b);
    logic [2*DRAW_W-1:0] p;
    p = '0;
    for (int k = 0; k < DRAW_W; k++) begin
      if (b[k]) begin
        p = p | ({{DRAW_W{1'b0}}, bits} << k);
      end
    end
    return p[2*DRAW_W-1:DRAW_W];
  endfunction

endpackage

### hdl/lbr_mul.sv
// ----------------------------------------------------------------------------
// lbr_mul
// Bit-serial LCG step: acc = a * LCG_MULT + LCG_ADD mod 2^48, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lbr_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lbr_pkg::STATE_W-1:0]  a,
  output logic                         done,
  output logic [lbr_pkg::STATE_W-1:0]  prod
);

  localparam int CNT_W = $clog2(lbr_pkg::MUL_STEPS + 1);

  logic [CNT_W-1:0]              cnt;
  logic [lbr_pkg::STATE_W-1:0]   acc;
  logic [lbr_pkg::STATE_W-1:0]   mcand;
  logic [lbr_pkg::MUL_STEPS-1:0] mplier;

  // step counter and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(lbr_pkg::MUL_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath, multiplier bits consumed LSB first
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= lbr_pkg::LCG_ADD;
      mcand  <= a;
      mplier <= lbr_pkg::LCG_MULT[lbr_pkg::MUL_STEPS-1:0];
    end else if (cnt != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

### hdl/lbr_div.sv
// ----------------------------------------------------------------------------
// lbr_div
// Restoring remainder unit: dividend mod divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lbr_pkg::DRAW_W-1:0]  dividend,
  input  logic [lbr_pkg::DRAW_W-1:0]  divisor,
  output logic                        done,
  output logic [lbr_pkg::DRAW_W-1:0]  rem
);

  localparam int CNT_W = $clog2(lbr_pkg::DIV_STEPS + 1);

  logic [CNT_W-1:0]             cnt;
  logic [lbr_pkg::DRAW_W-1:0]   dvd;
  logic [lbr_pkg::DRAW_W-1:0]   dsr;
  logic [lbr_pkg::DRAW_W:0]     trial;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, dvd[lbr_pkg::DRAW_W-1]};

  // step counter and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(lbr_pkg::DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // compare and subtract, dividend MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= lbr_pkg::DRAW_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[lbr_pkg::DRAW_W-1:0];
      end
      dvd <= dvd << 1;
    end
  end

endmodule

### hdl/lcg48_bounded_random_core.sv
// ----------------------------------------------------------------------------
// lcg48_bounded_random_core
// Bounded random numbers from a 48-bit linear congruential generator.
//
//   channel   dir   bus bits                     meaning
//   s_*       in    tuser[0] action              0 draw, 1 restart from seed
//                   tdata[30:0] bound            exclusive upper bound
//   m_*       out   tdata[30:0] value            drawn value, 0 on restart
//   cfg_*     in    cfg_data[47:0] seed          seed used by restart
//
// One item in flight. Restart goes from idle straight to the done state.
// Power-of-two bound: serial multiply, then shift scaling. Other bounds:
// serial multiply, serial remainder and bias check per pass; a rejected
// pass repeats. The output register lets the next item be taken while a
// result waits; a stalled output holds the engine only when its next
// result is ready. Synchronous reset loads the seed and state.
// ----------------------------------------------------------------------------
module lcg48_bounded_random_core (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] bound, [31] zero
  input  logic        s_tuser,   // [0] action
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] value, [31] zero
  // seed write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_data
);

  localparam int SW = lbr_pkg::STATE_W;
  localparam int DW = lbr_pkg::DRAW_W;

  lbr_pkg::lbr_state_t state, state_next;

  logic [SW-1:0] seed;
  logic [SW-1:0] lcg_state;
  logic [DW-1:0] bound;
  logic [DW-1:0] bits;
  logic [DW-1:0] res;

  logic          s_xfer;
  logic          out_free;
  logic          mul_start, mul_done;
  logic          div_start, div_done;
  logic          load_out;
  logic          biased;
  logic [SW-1:0] mul_prod;
  logic [DW-1:0] div_rem;
  logic [DW-1:0] new_bits;
  logic [DW+1:0] bias_sum;

  assign s_tready  = (state == lbr_pkg::ST_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign new_bits  = mul_prod[SW-1:SW-DW];

  // draw is biased when bits - value + bound - 1 reaches 2^31
  assign bias_sum = {2'b00, bits} - {2'b00, res} + {2'b00, bound} - (DW+2)'(1);
  assign biased   = (bias_sum[DW+1:DW] != 2'b00);

  lbr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (lcg_state),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_bits),
    .divisor  (bound),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit strobes
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      lbr_pkg::ST_IDLE: begin
        if (s_xfer) begin
          if (s_tuser == lbr_pkg::ACT_RESTART) begin
            state_next = lbr_pkg::ST_DONE;
          end else begin
            mul_start  = 1'b1;
            state_next = lbr_pkg::ST_MUL;
          end
        end
      end
      lbr_pkg::ST_MUL: begin
        if (mul_done) begin
          if (lbr_pkg::is_pow2(bound)) begin
            state_next = lbr_pkg::ST_DONE;
          end else begin
            div_start  = 1'b1;
            state_next = lbr_pkg::ST_DIV;
          end
        end
      end
      lbr_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lbr_pkg::ST_CHECK;
        end
      end
      lbr_pkg::ST_CHECK: begin
        if (biased) begin
          mul_start  = 1'b1;
          state_next = lbr_pkg::ST_MUL;
        end else begin
          state_next = lbr_pkg::ST_DONE;
        end
      end
      lbr_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = lbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbr_pkg::ST_IDLE;
      end
    endcase
  end

  // seed register and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= lbr_pkg::SEED_RESET;
      lcg_state <= lbr_pkg::SEED_RESET ^ lbr_pkg::LCG_MULT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed <= cfg_data;
      end
      if (s_xfer && s_tuser == lbr_pkg::ACT_RESTART) begin
        lcg_state <= seed ^ lbr_pkg::LCG_MULT;
      end else if (state == lbr_pkg::ST_MUL && mul_done) begin
        lcg_state <= mul_prod;
      end
    end
  end

  // item payload and working result
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      bound <= s_tdata[DW-1:0];
      res   <= '0;
    end else if (state == lbr_pkg::ST_MUL && mul_done) begin
      bits <= new_bits;
      if (lbr_pkg::is_pow2(bound)) begin
        res <= lbr_pkg::pow2_scale(new_bits, bound);
      end
    end else if (state == lbr_pkg::ST_DIV && div_done) begin
      res <= div_rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, res};
    end
  end

endmodule

### hdl/lbr_checker.sv
// ----------------------------------------------------------------------------
// lbr_checker
// Port-level checks of the bounded LCG generator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // only one item in flight: a transfer closes the input
  `ASSERT_CLK(a_one_item, clk, rst, s_tvalid && s_tready |=> !s_tready)

  // publishing a result returns the engine to idle
  `ASSERT_CLK(a_idle_after_out, clk, rst, $rose(m_tvalid) |-> s_tready)

  // the pad bit above the value stays zero
  `ASSERT_ALWAYS(a_pad_zero, clk, rst || !m_tvalid || !m_tdata[31])

endmodule

bind lcg48_bounded_random_core lbr_checker u_lbr_checker (.*);
